@@ rtl/bc7u_pkg.sv @@
// ----------------------------------------------------------------------------
// bc7u_pkg
// Shared types and the per-mode field layout table for the endpoint unpacker.
// ----------------------------------------------------------------------------
package bc7u_pkg;

    localparam int BLK_W = 128;
    localparam int POS_W = 8;
    localparam int IDX_W = 3;

    // layout names, one per BC7 mode number
    localparam logic [2:0] MODE_3S_PEND   = 3'd0;
    localparam logic [2:0] MODE_2S_PSHARE = 3'd1;
    localparam logic [2:0] MODE_3S_NOP    = 3'd2;
    localparam logic [2:0] MODE_2S_PEND   = 3'd3;
    localparam logic [2:0] MODE_ROT_ISEL  = 3'd4;
    localparam logic [2:0] MODE_ROT       = 3'd5;
    localparam logic [2:0] MODE_RGBA_PEND = 3'd6;
    localparam logic [2:0] MODE_2S_RGBA   = 3'd7;

    typedef struct packed {
        logic [1:0] subsets;
        logic [3:0] colour_bits;
        logic [3:0] alpha_bits;
        logic       per_end_pbit;
        logic       shared_pbit;
    } t_mode_desc;

    // one queued block, already classified by the front end
    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic [3:0]       colour_bits;
        logic [3:0]       alpha_bits;
        logic             per_end_pbit;
        logic             has_pbit;
        logic [IDX_W-1:0] last_idx;
        logic [6:0]       start_bit;
        logic [POS_W-1:0] stride;
        logic [POS_W-1:0] alpha_base;
        logic [POS_W-1:0] p_base;
        logic [POS_W-1:0] next_bit;
        logic             overrun;
    } t_job;

    function automatic t_mode_desc mode_lookup(input logic [2:0] mode);
        t_mode_desc d;
        unique case (mode)
            MODE_3S_PEND:   d = '{2'd3, 4'd4, 4'd0, 1'b1, 1'b0};
            MODE_2S_PSHARE: d = '{2'd2, 4'd6, 4'd0, 1'b0, 1'b1};
            MODE_3S_NOP:    d = '{2'd3, 4'd5, 4'd0, 1'b0, 1'b0};
            MODE_2S_PEND:   d = '{2'd2, 4'd7, 4'd0, 1'b1, 1'b0};
            MODE_ROT_ISEL:  d = '{2'd1, 4'd5, 4'd6, 1'b0, 1'b0};
            MODE_ROT:       d = '{2'd1, 4'd7, 4'd8, 1'b0, 1'b0};
            MODE_RGBA_PEND: d = '{2'd1, 4'd7, 4'd7, 1'b1, 1'b0};
            default:        d = '{2'd2, 4'd5, 4'd5, 1'b1, 1'b0};
        endcase
        return d;
    endfunction

endpackage

@@ rtl/bc7_endpoint_unpack.sv @@
// ----------------------------------------------------------------------------
// bc7_endpoint_unpack
// Unpacks and expands the endpoint colours of one BC7 block per command.
//
// Input: raise start with the block halves, mode number and start bit;
// the beat is taken on a rising edge where start is high and busy is low.
// busy is high only while the block queue (QUEUE_DEPTH entries) is full.
// Output: one result per endpoint (2, 4 or 6, by mode), each shown for one
// cycle with o_strobe high; o_last_endpoint marks the final one. Results of
// a block come in consecutive cycles and the receiver cannot stall them.
// A block waits in the queue until the back end is free, then passes into
// the back-end job register and from there into the output registers.
// Throughput: the back end emits one endpoint per cycle while it holds a
// block; new blocks are accepted meanwhile while the queue has room.
// Reset (synchronous, active low) empties the queue and drops any block
// in flight; no result is strobed until a new block is accepted.
// ----------------------------------------------------------------------------
module bc7_endpoint_unpack import bc7u_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [63:0]      i_block_low,
    input  logic [63:0]      i_block_high,
    input  logic [2:0]       i_mode_number,
    input  logic [6:0]       i_start_bit,
    output logic             o_strobe,
    output logic [IDX_W-1:0] o_endpoint_index,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [POS_W-1:0] o_next_bit,
    output logic             o_overrun,
    output logic             o_last_endpoint
);

    t_job push_job;
    t_job head_job;
    logic push, pop, q_empty, q_full;

    bc7u_front u_front (
        .i_start       (start),
        .i_block_low   (i_block_low),
        .i_block_high  (i_block_high),
        .i_mode_number (i_mode_number),
        .i_start_bit   (i_start_bit),
        .i_full        (q_full),
        .o_busy        (busy),
        .o_push        (push),
        .o_job         (push_job)
    );

    bc7u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    bc7u_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head_job),
        .i_empty          (q_empty),
        .o_pop            (pop),
        .o_strobe         (o_strobe),
        .o_endpoint_index (o_endpoint_index),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_alpha          (o_alpha),
        .o_next_bit       (o_next_bit),
        .o_overrun        (o_overrun),
        .o_last_endpoint  (o_last_endpoint)
    );

endmodule

@@ rtl/bc7u_front.sv @@
// ----------------------------------------------------------------------------
// bc7u_front
// Accepts a block beat and works out its field layout: endpoint count,
// component stride, alpha and p-bit base positions, end position, overrun.
// ----------------------------------------------------------------------------
module bc7u_front import bc7u_pkg::*; (
    input  logic             i_start,
    input  logic [63:0]      i_block_low,
    input  logic [63:0]      i_block_high,
    input  logic [2:0]       i_mode_number,
    input  logic [6:0]       i_start_bit,
    input  logic             i_full,
    output logic             o_busy,
    output logic             o_push,
    output t_job             o_job
);

    t_mode_desc      desc;
    logic [2:0]      ends;
    logic [POS_W-1:0] stride;
    logic [POS_W-1:0] alpha_span;
    logic [POS_W-1:0] pbits;
    logic [POS_W-1:0] alpha_base;
    logic [POS_W-1:0] p_base;
    logic [POS_W-1:0] next_bit;

    always_comb begin
        desc       = mode_lookup(i_mode_number);
        ends       = {desc.subsets, 1'b0};
        stride     = POS_W'(ends) * POS_W'(desc.colour_bits);
        alpha_span = POS_W'(ends) * POS_W'(desc.alpha_bits);
        priority if (desc.per_end_pbit) begin
            pbits = POS_W'(ends);
        end else if (desc.shared_pbit) begin
            pbits = POS_W'(desc.subsets);
        end else begin
            pbits = '0;
        end
        alpha_base = POS_W'(i_start_bit) + POS_W'(3) * stride;
        p_base     = alpha_base + alpha_span;
        next_bit   = p_base + pbits;
    end

    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    always_comb begin
        o_job.blk          = {i_block_high, i_block_low};
        o_job.colour_bits  = desc.colour_bits;
        o_job.alpha_bits   = desc.alpha_bits;
        o_job.per_end_pbit = desc.per_end_pbit;
        o_job.has_pbit     = desc.per_end_pbit || desc.shared_pbit;
        o_job.last_idx     = ends - 3'd1;
        o_job.start_bit    = i_start_bit;
        o_job.stride       = stride;
        o_job.alpha_base   = alpha_base;
        o_job.p_base       = p_base;
        o_job.next_bit     = next_bit;
        // last bit read sits at next_bit - 1
        o_job.overrun      = next_bit > POS_W'(BLK_W);
    end

endmodule

@@ rtl/bc7u_queue.sv @@
// ----------------------------------------------------------------------------
// bc7u_queue
// Small fifo of classified blocks between the front end and the back end.
// ----------------------------------------------------------------------------
module bc7u_queue import bc7u_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_cnt    = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

@@ rtl/bc7u_back.sv @@
// ----------------------------------------------------------------------------
// bc7u_back
// Walks the endpoints of the head block, one per cycle: pulls the colour,
// alpha and p-bit fields, expands them to 8 bits and registers the result.
// ----------------------------------------------------------------------------
module bc7u_back import bc7u_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_job             i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_strobe,
    output logic [IDX_W-1:0] o_endpoint_index,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [POS_W-1:0] o_next_bit,
    output logic             o_overrun,
    output logic             o_last_endpoint
);

    localparam int EXT_W = 1 << POS_W;

    logic             r_active, n_active;
    t_job             r_job;
    logic [IDX_W-1:0] r_e;
    logic [POS_W-1:0] r_pos_c;
    logic [POS_W-1:0] r_pos_a;

    logic [EXT_W+7:0] blk_ext;
    logic [POS_W-1:0] pos_g, pos_b, pos_p;
    logic             pbit;
    logic             is_last;
    logic [7:0]       red, green, blue, alpha;

    function automatic logic [7:0] field_mask(input logic [3:0] w);
        logic [8:0] m;
        m = (9'd1 << w) - 9'd1;
        return m[7:0];
    endfunction

    // replicate the top bits of a w-bit value down to fill 8 bits
    function automatic logic [7:0] expand8(input logic [7:0] v, input logic [3:0] w);
        logic [15:0] t;
        logic [7:0]  s;
        t = {8'd0, v} << (4'd8 - w);
        s = t[7:0];
        return s | (s >> w);
    endfunction

    function automatic logic [7:0] unpack_comp(input logic [7:0] win, input logic [3:0] w,
                                               input logic has_p, input logic p);
        logic [7:0] raw;
        raw = win & field_mask(w);
        if (has_p) begin
            return expand8({raw[6:0], p}, w + 4'd1);
        end else begin
            return expand8(raw, w);
        end
    endfunction

    always_comb begin
        // bits past the block read as zero
        blk_ext = {(EXT_W + 8 - BLK_W)'(0), r_job.blk};
        pos_g   = r_pos_c + r_job.stride;
        pos_b   = pos_g + r_job.stride;
        pos_p   = r_job.p_base + (r_job.per_end_pbit ? POS_W'(r_e) : POS_W'(r_e >> 1));
        pbit    = blk_ext[pos_p];
        red     = unpack_comp(blk_ext[r_pos_c +: 8], r_job.colour_bits, r_job.has_pbit, pbit);
        green   = unpack_comp(blk_ext[pos_g +: 8], r_job.colour_bits, r_job.has_pbit, pbit);
        blue    = unpack_comp(blk_ext[pos_b +: 8], r_job.colour_bits, r_job.has_pbit, pbit);
        if (r_job.alpha_bits == 4'd0) begin
            alpha = 8'hFF;
        end else begin
            alpha = unpack_comp(blk_ext[r_pos_a +: 8], r_job.alpha_bits,
                                r_job.has_pbit, pbit);
        end
    end

    assign is_last = (r_e == r_job.last_idx);
    assign o_pop   = !i_empty && (!r_active || is_last);

    always_comb begin
        priority if (o_pop) begin
            n_active = 1'b1;
        end else if (r_active && is_last) begin
            n_active = 1'b0;
        end else begin
            n_active = r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            o_strobe <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job   <= i_head;
            r_e     <= '0;
            r_pos_c <= POS_W'(i_head.start_bit);
            r_pos_a <= i_head.alpha_base;
        end else if (r_active) begin
            r_e     <= r_e + IDX_W'(1);
            r_pos_c <= r_pos_c + POS_W'(r_job.colour_bits);
            r_pos_a <= r_pos_a + POS_W'(r_job.alpha_bits);
        end
        o_endpoint_index <= r_e;
        o_red            <= red;
        o_green          <= green;
        o_blue           <= blue;
        o_alpha          <= alpha;
        o_next_bit       <= r_job.next_bit;
        o_overrun        <= r_job.overrun;
        o_last_endpoint  <= is_last;
    end

    // results of one block come out in consecutive cycles
    a_burst_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_endpoint |=> o_strobe)
        else $error("endpoint burst broken");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_endpoint |=>
            o_endpoint_index == $past(o_endpoint_index) + IDX_W'(1))
        else $error("endpoint index did not step");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_endpoint |->
            (o_endpoint_index == 3'd1 || o_endpoint_index == 3'd3 ||
             o_endpoint_index == 3'd5))
        else $error("bad final endpoint index");

    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_e <= r_job.last_idx)
        else $error("endpoint counter ran past block");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Block-level bench for the BC7 endpoint unpacker. A clocked driver sends
// directed and random blocks over the start/busy command port with random
// gaps. A golden predictor expands the endpoints of each accepted block.
// A clocked monitor checks every strobed endpoint against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top import bc7u_pkg::*; ();

    localparam int N_ITEMS     = 410;
    localparam int QUIET_TAIL  = 30;
    localparam int STALL_LIMIT = 200;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [2:0]  mode;
        logic [6:0]  sbit;
        logic [3:0]  gap;
    } t_block_cmd;

    typedef struct packed {
        logic [2:0] idx;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic [7:0] nxt;
        logic       ovr;
        logic       last;
    } t_endpoint;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] i_block_low = '0;
    logic [63:0] i_block_high = '0;
    logic [2:0]  i_mode_number = '0;
    logic [6:0]  i_start_bit = '0;

    logic             o_strobe;
    logic [IDX_W-1:0] o_endpoint_index;
    logic [7:0]       o_red;
    logic [7:0]       o_green;
    logic [7:0]       o_blue;
    logic [7:0]       o_alpha;
    logic [POS_W-1:0] o_next_bit;
    logic             o_overrun;
    logic             o_last_endpoint;

    t_block_cmd pending_blocks[$];
    t_endpoint  expected_ends[$];
    t_block_cmd cur_block = '0;
    int         idle_left = 0;
    int         err_cnt = 0;
    int         stall_cycles = 0;

    bc7_endpoint_unpack dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_block_low      (i_block_low),
        .i_block_high     (i_block_high),
        .i_mode_number    (i_mode_number),
        .i_start_bit      (i_start_bit),
        .o_strobe         (o_strobe),
        .o_endpoint_index (o_endpoint_index),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_alpha          (o_alpha),
        .o_next_bit       (o_next_bit),
        .o_overrun        (o_overrun),
        .o_last_endpoint  (o_last_endpoint)
    );

    function automatic t_mode_desc mode_fields(input logic [2:0] m);
        t_mode_desc d;
        d.subsets = 2'd1;
        d.colour_bits = 4'd7;
        d.alpha_bits = 4'd0;
        d.per_end_pbit = 1'b0;
        d.shared_pbit = 1'b0;
        case (m)
            MODE_3S_PEND: begin
                d.subsets = 2'd3; d.colour_bits = 4'd4; d.per_end_pbit = 1'b1;
            end
            MODE_2S_PSHARE: begin
                d.subsets = 2'd2; d.colour_bits = 4'd6; d.shared_pbit = 1'b1;
            end
            MODE_3S_NOP: begin
                d.subsets = 2'd3; d.colour_bits = 4'd5;
            end
            MODE_2S_PEND: begin
                d.subsets = 2'd2; d.per_end_pbit = 1'b1;
            end
            MODE_ROT_ISEL: begin
                d.colour_bits = 4'd5; d.alpha_bits = 4'd6;
            end
            MODE_ROT: begin
                d.alpha_bits = 4'd8;
            end
            MODE_RGBA_PEND: begin
                d.alpha_bits = 4'd7; d.per_end_pbit = 1'b1;
            end
            default: begin
                d.subsets = 2'd2; d.colour_bits = 4'd5; d.alpha_bits = 4'd5;
                d.per_end_pbit = 1'b1;
            end
        endcase
        return d;
    endfunction

    // bits past the end of the block read as zero
    function automatic int field_at(input logic [127:0] blk, input int p, input int w);
        int v;
        v = 0;
        for (int i = 0; i < w; i++)
            if (p + i < 128 && blk[p + i])
                v |= 1 << i;
        return v;
    endfunction

    function automatic int widen8(input int v, input int w);
        int x;
        x = (v << (8 - w)) & 8'hFF;
        return (x | (x >> w)) & 8'hFF;
    endfunction

    function automatic void predict_endpoints(input t_block_cmd c);
        t_mode_desc   d;
        logic [127:0] blk;
        int           pos, n, cb, ab, w, p;
        int           raw[6][4];
        int           pb[6];
        int           val[4];
        bit           has_p;
        t_endpoint    res;
        d = mode_fields(c.mode);
        blk = {c.hi, c.lo};
        pos = int'(c.sbit);
        n = int'(d.subsets) * 2;
        cb = int'(d.colour_bits);
        ab = int'(d.alpha_bits);
        has_p = d.per_end_pbit || d.shared_pbit;
        for (int e = 0; e < 6; e++)
            pb[e] = 0;
        // all reds, then greens, then blues
        for (int ch = 0; ch < 3; ch++)
            for (int e = 0; e < n; e++) begin
                raw[e][ch] = field_at(blk, pos, cb);
                pos += cb;
            end
        for (int e = 0; e < n; e++) begin
            raw[e][3] = field_at(blk, pos, ab);
            pos += ab;
        end
        if (d.per_end_pbit) begin
            for (int e = 0; e < n; e++) begin
                pb[e] = field_at(blk, pos, 1);
                pos += 1;
            end
        end else if (d.shared_pbit) begin
            for (int s = 0; s < int'(d.subsets); s++) begin
                p = field_at(blk, pos, 1);
                pos += 1;
                pb[2*s] = p;
                pb[2*s+1] = p;
            end
        end
        for (int e = 0; e < n; e++) begin
            for (int ch = 0; ch < 4; ch++) begin
                w = (ch < 3) ? cb : ab;
                if (w == 0)
                    val[ch] = 255;
                else if (has_p)
                    val[ch] = widen8((raw[e][ch] << 1) | pb[e], w + 1);
                else
                    val[ch] = widen8(raw[e][ch], w);
            end
            res.idx  = e[2:0];
            res.r    = val[0][7:0];
            res.g    = val[1][7:0];
            res.b    = val[2][7:0];
            res.a    = val[3][7:0];
            res.nxt  = pos[7:0];
            // any bit read at 128 or above leaves pos past 128
            res.ovr  = (pos > 128);
            res.last = (e == n - 1);
            expected_ends.push_back(res);
        end
    endfunction

    function automatic void add_block(input logic [63:0] lo, input logic [63:0] hi,
                                      input logic [2:0] m, input logic [6:0] sb,
                                      input logic [3:0] gap);
        pending_blocks.push_back(t_block_cmd'{lo, hi, m, sb, gap});
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: one command beat per accepted block, gaps come with the block
    always @(posedge i_clk) begin
        t_block_cmd nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy)
                predict_endpoints(cur_block);
            if (start && busy) begin
                // hold the beat until taken
            end else if (idle_left != 0) begin
                start <= 1'b0;
                idle_left <= idle_left - 1;
            end else if (pending_blocks.size() != 0) begin
                nxt = pending_blocks.pop_front();
                if (nxt.gap != 0) begin
                    idle_left <= int'(nxt.gap) - 1;
                    nxt.gap = '0;
                    pending_blocks.push_front(nxt);
                    start <= 1'b0;
                end else begin
                    cur_block <= nxt;
                    i_block_low <= nxt.lo;
                    i_block_high <= nxt.hi;
                    i_mode_number <= nxt.mode;
                    i_start_bit <= nxt.sbit;
                    start <= 1'b1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results cannot be held off, check each strobed endpoint
    always @(posedge i_clk) begin
        t_endpoint got, want;
        if (i_rst_n && o_strobe) begin
            got = t_endpoint'{o_endpoint_index, o_red, o_green, o_blue, o_alpha,
                              o_next_bit, o_overrun, o_last_endpoint};
            if (expected_ends.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected endpoint idx %0d rgba %0d %0d %0d %0d",
                             $time, got.idx, got.r, got.g, got.b, got.a);
            end else begin
                want = expected_ends.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display({"%0t: endpoint mismatch: expected idx %0d rgba %0d %0d %0d",
                                  " %0d next %0d ovr %0d last %0d, actual idx %0d rgba %0d",
                                  " %0d %0d %0d next %0d ovr %0d last %0d"},
                                 $time, want.idx, want.r, want.g, want.b, want.a, want.nxt,
                                 want.ovr, want.last, got.idx, got.r, got.g, got.b, got.a,
                                 got.nxt, got.ovr, got.last);
                end
            end
        end
    end

    // watchdog on cycles with neither a command beat nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_mode_desc  d;
        logic [2:0]  m;
        logic [63:0] lo, hi;
        int          need, n_dir, n_rand, sb;
        bit          gappy;

        // directed: every mode with empty and full blocks, then overrun and
        // a field crossing the half boundary
        for (int k = 0; k < 8; k++) begin
            add_block('0, '0, k[2:0], 7'd0, 4'd0);
            add_block('1, '1, k[2:0], 7'd0, 4'd0);
        end
        add_block('1, '1, MODE_3S_PEND, 7'd127, 4'd0);
        add_block('1, '1, MODE_RGBA_PEND, 7'd100, 4'd0);
        add_block({$urandom, $urandom}, {$urandom, $urandom}, MODE_ROT, 7'd127, 4'd0);
        add_block({16{4'hA}}, {16{4'h5}}, MODE_2S_PSHARE, 7'd5, 4'd0);
        add_block({16{4'h5}}, {16{4'hA}}, MODE_2S_PEND, 7'd40, 4'd0);
        add_block('1, '0, MODE_3S_NOP, 7'd38, 4'd0);
        add_block('0, '1, MODE_2S_RGBA, 7'd44, 4'd0);
        add_block('1, '1, MODE_ROT_ISEL, 7'd86, 4'd0);
        n_dir = pending_blocks.size();
        n_rand = N_ITEMS - n_dir;

        for (int k = 0; k < n_rand; k++) begin
            m = 3'($urandom_range(0, 7));
            d = mode_fields(m);
            need = int'(d.subsets) * 2 * (3 * int'(d.colour_bits) + int'(d.alpha_bits));
            if (d.per_end_pbit)
                need += int'(d.subsets) * 2;
            else if (d.shared_pbit)
                need += int'(d.subsets);
            // most blocks fit, the rest may run past the end
            if ($urandom_range(0, 9) < 7)
                sb = $urandom_range(0, 128 - need);
            else
                sb = $urandom_range(0, 127);
            case ($urandom_range(0, 9))
                0: begin lo = '1; hi = '1; end
                1: begin lo = '0; hi = '0; end
                default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
            endcase
            // alternate quiet and gappy stretches, no gaps at the tail
            gappy = ((k / 32) % 2 == 1) && (k < n_rand - QUIET_TAIL);
            if (gappy && $urandom_range(0, 1) == 1)
                add_block(lo, hi, m, sb[6:0], 4'($urandom_range(1, 9)));
            else
                add_block(lo, hi, m, sb[6:0], 4'd0);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (pending_blocks.size() != 0 || start);
        while (expected_ends.size() != 0) @(negedge i_clk);
        repeat (12) @(posedge i_clk);

        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
